[rtl/repb_pkg.sv]
// shared types and codes of the rpc envelope byte parser
`default_nettype none
package repb_pkg;

	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_TYPE     = 3'd1;
	localparam logic [2:0] KIND_ID       = 3'd2;
	localparam logic [2:0] KIND_ID_FLAG  = 3'd3;
	localparam logic [2:0] KIND_ERR_CODE = 3'd4;
	localparam logic [2:0] KIND_STR_LEN  = 3'd5;
	localparam logic [2:0] KIND_CONTENT  = 3'd6;

	localparam logic [3:0] F_NONE        = 4'd0;
	localparam logic [3:0] F_REQ_ID      = 4'd2;
	localparam logic [3:0] F_REQ_METHOD  = 4'd3;
	localparam logic [3:0] F_REQ_PARAMS  = 4'd4;
	localparam logic [3:0] F_NOTE_METHOD = 4'd5;
	localparam logic [3:0] F_NOTE_PARAMS = 4'd6;
	localparam logic [3:0] F_RESP_ID     = 4'd7;
	localparam logic [3:0] F_RESP_RESULT = 4'd8;
	localparam logic [3:0] F_ERR_ID_FLAG = 4'd9;
	localparam logic [3:0] F_ERR_ID      = 4'd10;
	localparam logic [3:0] F_ERR_CODE    = 4'd11;
	localparam logic [3:0] F_ERR_MSG     = 4'd12;
	localparam logic [3:0] F_ERR_DATA    = 4'd13;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_UNKNOWN  = 4'd1;
	localparam logic [3:0] ST_TRAILING = 4'd14;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  fcode;
		logic [63:0] value;
		logic        done;
		logic [3:0]  status;
	} rec_t;

endpackage
`default_nettype wire

[rtl/rpc_envelope_byte_parser.sv]
// Byte-serial parser for one rpc envelope per message: type byte, little-endian ids and
// codes, and LEB128 length-prefixed strings. One byte is accepted every cycle while full
// is low; each byte gives at most one result beat, and the final byte always gives one,
// carrying done_res and the status. A result passes through the record queue and then
// the output register before it appears on the output ports. The rate is set by the
// parse step of the front part (64-bit length accumulate and content countdown); a
// QUEUE_DEPTH-entry record queue and an output register decouple it from the result
// side.
`default_nettype none
module rpc_envelope_byte_parser import repb_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  in_byte,
	input  wire logic        last,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       kind,
	output logic [2:0]       section,
	output logic [63:0]      field_value,
	output logic             done_res,
	output logic [3:0]       status
);

	rec_t rec;
	rec_t head;
	logic rec_we;
	logic head_valid;
	logic head_pop;

	repb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_byte (in_byte),
		.last    (last),
		.q_full  (full),
		.rec_we  (rec_we),
		.rec     (rec)
	);

	repb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (rec_we),
		.wr_data  (rec),
		.full     (full),
		.rd_en    (head_pop),
		.rd_data  (head),
		.rd_valid (head_valid)
	);

	repb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.head_pop    (head_pop),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.section     (section),
		.field_value (field_value),
		.done_res    (done_res),
		.status      (status)
	);

endmodule
`default_nettype wire

[rtl/repb_front.sv]
// front part: envelope walk, one byte per cycle while the queue is not full, emits raw result records
`default_nettype none
module repb_front import repb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] in_byte,
	input  wire logic       last,
	input  wire logic       q_full,
	output logic            rec_we,
	output rec_t            rec
);

	localparam logic [2:0] PH_TYPE    = 3'd0;
	localparam logic [2:0] PH_FIELD   = 3'd1;
	localparam logic [2:0] PH_CONTENT = 3'd2;
	localparam logic [2:0] PH_DONE    = 3'd3;
	localparam logic [2:0] PH_DRAIN   = 3'd4;

	localparam logic [3:0] MT_REQ  = 4'd1;
	localparam logic [3:0] MT_NOTE = 4'd2;
	localparam logic [3:0] MT_RESP = 4'd3;
	localparam logic [3:0] MT_ERR  = 4'd4;

	function automatic logic [3:0] next_of(input logic [3:0] code);
		logic [3:0] n;
		unique case (code)
			F_REQ_ID:      n = F_REQ_METHOD;
			F_REQ_METHOD:  n = F_REQ_PARAMS;
			F_NOTE_METHOD: n = F_NOTE_PARAMS;
			F_RESP_ID:     n = F_RESP_RESULT;
			F_ERR_ID:      n = F_ERR_CODE;
			F_ERR_CODE:    n = F_ERR_MSG;
			F_ERR_MSG:     n = F_ERR_DATA;
			default:       n = F_NONE;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] first_of(input logic [7:0] t);
		logic [3:0] n;
		unique case (t[3:0])
			MT_REQ:  n = F_REQ_ID;
			MT_NOTE: n = F_NOTE_METHOD;
			MT_RESP: n = F_RESP_ID;
			MT_ERR:  n = F_ERR_ID_FLAG;
			default: n = F_NONE;
		endcase
		return n;
	endfunction

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  field_q, field_d;
	logic [3:0]  bcount_q, bcount_d;
	logic [63:0] acc_q, acc_d;
	logic [6:0]  vshift_q, vshift_d;
	logic [63:0] left_q, left_d;
	logic [3:0]  fault_q, fault_d;

	logic        have;
	logic [2:0]  r_kind;
	logic [63:0] r_value;
	logic        take;

	assign take = push && !q_full;

	always_comb begin
		logic [63:0] acc_n;
		logic [3:0]  nf;
		phase_d  = phase_q;
		field_d  = field_q;
		bcount_d = bcount_q;
		acc_d    = acc_q;
		vshift_d = vshift_q;
		left_d   = left_q;
		fault_d  = fault_q;
		have     = 1'b0;
		r_kind   = KIND_NONE;
		r_value  = '0;
		acc_n    = '0;
		nf       = F_NONE;
		unique case (phase_q)
			PH_TYPE: begin
				have    = 1'b1;
				r_kind  = KIND_TYPE;
				r_value = {56'd0, in_byte};
				if (in_byte >= 8'd1 && in_byte <= 8'd4) begin
					nf = first_of(in_byte);
				end else begin
					fault_d = ST_UNKNOWN;
					phase_d = PH_DRAIN;
				end
			end
			PH_FIELD: begin
				if (field_q == F_REQ_ID || field_q == F_RESP_ID || field_q == F_ERR_ID) begin
					acc_n    = acc_q | ({56'd0, in_byte} << {bcount_q[2:0], 3'b000});
					acc_d    = acc_n;
					bcount_d = bcount_q + 4'd1;
					if (bcount_q >= 4'd7) begin
						have    = 1'b1;
						r_kind  = KIND_ID;
						r_value = acc_n;
						nf      = next_of(field_q);
					end
				end else if (field_q == F_ERR_ID_FLAG) begin
					have    = 1'b1;
					r_kind  = KIND_ID_FLAG;
					r_value = {56'd0, in_byte};
					nf      = (in_byte != 8'd0) ? F_ERR_ID : F_ERR_CODE;
				end else if (field_q == F_ERR_CODE) begin
					acc_n    = acc_q | ({56'd0, in_byte} << {bcount_q[1:0], 3'b000});
					acc_d    = acc_n;
					bcount_d = bcount_q + 4'd1;
					if (bcount_q >= 4'd3) begin
						have    = 1'b1;
						r_kind  = KIND_ERR_CODE;
						r_value = {32'd0, acc_n[31:0]};
						nf      = next_of(field_q);
					end
				end else begin
					acc_n = acc_q | ({57'd0, in_byte[6:0]} << vshift_q[5:0]);
					acc_d = acc_n;
					if (!in_byte[7]) begin
						have    = 1'b1;
						r_kind  = KIND_STR_LEN;
						r_value = acc_n;
						if (acc_n == 64'd0) begin
							nf = next_of(field_q);
						end else begin
							left_d  = acc_n;
							phase_d = PH_CONTENT;
						end
					end else begin
						vshift_d = vshift_q + 7'd7;
						if (vshift_d >= 7'd64) begin
							fault_d = field_q;
							phase_d = PH_DRAIN;
						end
					end
				end
			end
			PH_CONTENT: begin
				if (field_q != F_ERR_DATA) begin
					have    = 1'b1;
					r_kind  = KIND_CONTENT;
					r_value = {56'd0, in_byte};
				end
				left_d = left_q - 64'd1;
				if (left_q == 64'd1) begin
					nf = next_of(field_q);
				end
			end
			PH_DONE: begin
				fault_d = ST_TRAILING;
				phase_d = PH_DRAIN;
			end
			default: begin
			end
		endcase
		// a field boundary, either from the type byte or a finished field
		if ((phase_q == PH_TYPE && phase_d != PH_DRAIN)
				|| (phase_q == PH_FIELD && have && phase_d == PH_FIELD)
				|| (phase_q == PH_CONTENT && left_q == 64'd1)) begin
			field_d  = nf;
			bcount_d = '0;
			acc_d    = '0;
			vshift_d = '0;
			left_d   = '0;
			phase_d  = (nf == F_NONE) ? PH_DONE : PH_FIELD;
		end
	end

	always_comb begin
		rec.kind   = r_kind;
		rec.fcode  = field_q;
		rec.value  = r_value;
		rec.done   = last;
		rec.status = ST_OK;
		if (last) begin
			if (fault_d != ST_OK) begin
				rec.status = fault_d;
			end else if (phase_d == PH_DONE) begin
				rec.status = ST_OK;
			end else begin
				rec.status = field_d;
			end
		end
		rec_we = take && (have || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			field_q  <= F_NONE;
			bcount_q <= '0;
			acc_q    <= '0;
			vshift_q <= '0;
			left_q   <= '0;
			fault_q  <= ST_OK;
		end else if (take) begin
			if (last) begin
				phase_q  <= PH_TYPE;
				field_q  <= F_NONE;
				bcount_q <= '0;
				acc_q    <= '0;
				vshift_q <= '0;
				left_q   <= '0;
				fault_q  <= ST_OK;
			end else begin
				phase_q  <= phase_d;
				field_q  <= field_d;
				bcount_q <= bcount_d;
				acc_q    <= acc_d;
				vshift_q <= vshift_d;
				left_q   <= left_d;
				fault_q  <= fault_d;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/repb_queue.sv]
// short record queue between front and back parts
`default_nettype none
module repb_queue import repb_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire rec_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output rec_t      rd_data,
	output logic      rd_valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t          mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/repb_back.sv]
// back part: section lookup, code sign extension and the output register
`default_nettype none
module repb_back import repb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rec_t        head,
	input  wire logic        head_valid,
	output logic             head_pop,
	input  wire logic        pop,
	output logic             empty,
	output logic [2:0]       kind,
	output logic [2:0]       section,
	output logic [63:0]      field_value,
	output logic             done_res,
	output logic [3:0]       status
);

	function automatic logic [2:0] section_of(input logic [3:0] code);
		logic [2:0] s;
		unique case (code)
			F_REQ_METHOD, F_NOTE_METHOD: s = 3'd0;
			F_REQ_PARAMS, F_NOTE_PARAMS: s = 3'd1;
			F_RESP_RESULT:               s = 3'd2;
			F_ERR_MSG:                   s = 3'd3;
			F_ERR_DATA:                  s = 3'd4;
			default:                     s = 3'd0;
		endcase
		return s;
	endfunction

	logic        valid_q;
	logic [2:0]  kind_q;
	logic [2:0]  section_q;
	logic [63:0] value_q;
	logic        done_q;
	logic [3:0]  status_q;

	assign head_pop    = head_valid && (!valid_q || pop);
	assign empty       = !valid_q;
	assign kind        = kind_q;
	assign section     = section_q;
	assign field_value = value_q;
	assign done_res    = done_q;
	assign status      = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (head_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			kind_q   <= head.kind;
			done_q   <= head.done;
			status_q <= head.status;
			if (head.kind == KIND_STR_LEN || head.kind == KIND_CONTENT) begin
				section_q <= section_of(head.fcode);
			end else begin
				section_q <= 3'd0;
			end
			if (head.kind == KIND_ERR_CODE) begin
				value_q <= {{32{head.value[31]}}, head.value[31:0]};
			end else begin
				value_q <= head.value;
			end
		end
	end

endmodule
`default_nettype wire
